### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands on the aclk / aresetn clock and reset pair.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every aclk edge outside reset
`define SFH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// check that a condition implies another in the next cycle
`define SFH_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

### src/sfh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfh_pkg
// Constants, command types and key selection for the square-fold hash.
// ----------------------------------------------------------------------------
package sfh_pkg;

    localparam int          LENGTH_BITS_DEF = 32;
    localparam int          SEED_W          = 64;
    localparam int          LEN_W           = 32;
    localparam int          WORD_W          = 64;
    localparam int          MIX_ROT         = 17;
    localparam logic [63:0] GOLD            = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIXK1           = 64'h85EBCA77C2B2AE3D;
    localparam logic [63:0] MIXK2           = 64'hBF58476D1CE4E5B9;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LEN0,
        OP_LEN1,
        OP_LEN2,
        OP_LEN3,
        OP_PREP,
        OP_SQ0,
        OP_SQ1,
        OP_SQ2,
        OP_SQ3,
        OP_FIN,
        OP_LOAD
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN0,
        ST_LEN1,
        ST_LEN2,
        ST_LEN3,
        ST_PREP,
        ST_SQ0,
        ST_SQ1,
        ST_SQ2,
        ST_SQ3,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t        op;
        logic       fin;
        logic [1:0] round;
    } cmd_t;

    typedef struct packed {
        logic in_msg;
        logic rem_zero;
    } status_t;

    function automatic logic [63:0] mix_key(input logic [1:0] sel);
        logic [63:0] k;
        case (sel)
            2'd0:    k = GOLD;
            2'd1:    k = MIXK1;
            2'd2:    k = MIXK2;
            default: k = GOLD;
        endcase
        return k;
    endfunction

endpackage

### src/sfh_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfh_datapath
// Lane accumulators, byte count, shared 32x32 multiplier and square-fold mix.
// ----------------------------------------------------------------------------
module sfh_datapath
    import sfh_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output status_t             st,
    input  logic [SEED_W-1:0]   seed,
    input  logic [LEN_W-1:0]    message_length,
    input  logic [WORD_W-1:0]   data_word,
    output logic [63:0]         digest
);

    logic [63:0]            acc_reg [4];
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic [1:0]             slot_reg, slot_next;
    logic                   full_reg, full_next;
    logic                   in_msg_reg, in_msg_next;
    logic [63:0]            word_reg;
    logic [63:0]            z_reg;
    logic [1:0]             lane_reg;
    logic [63:0]            prod_reg;
    logic [63:0]            p00_reg;
    logic [63:0]            p01_reg;
    logic [63:0]            digest_reg;

    logic                   first;
    logic                   full_eff;
    logic                   rem_ge8;
    logic [1:0]             lane_eff;
    logic [63:0]            word_mask;
    logic [63:0]            len64;
    logic [31:0]            mul_a, mul_b;
    logic [63:0]            len_prod;
    logic [33:0]            mid;
    logic [63:0]            sq_lo, sq_hi, fold_k, mix_out;

    assign first    = !in_msg_reg;
    assign rem_ge8  = (rem_reg >= LENGTH_BITS'(8));
    assign full_eff = full_reg || (slot_reg == 2'd0 && rem_reg >= LENGTH_BITS'(32));
    assign lane_eff = full_eff ? slot_reg : 2'd0;
    assign len64    = 64'(rem_reg);

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            word_mask[i*8 +: 8] = (rem_ge8 || 3'(i) < rem_reg[2:0]) ? word_reg[i*8 +: 8] : 8'h00;
        end
    end

    always_comb begin
        case (cmd.op)
            OP_LEN0: begin
                mul_a = len64[31:0];
                mul_b = GOLD[31:0];
            end
            OP_LEN1: begin
                mul_a = len64[31:0];
                mul_b = GOLD[63:32];
            end
            OP_LEN2: begin
                mul_a = len64[63:32];
                mul_b = GOLD[31:0];
            end
            OP_SQ1: begin
                mul_a = z_reg[31:0];
                mul_b = z_reg[63:32];
            end
            OP_SQ2: begin
                mul_a = z_reg[63:32];
                mul_b = z_reg[63:32];
            end
            default: begin
                mul_a = z_reg[31:0];
                mul_b = z_reg[31:0];
            end
        endcase
    end

    assign len_prod = p00_reg + {p01_reg[31:0] + prod_reg[31:0], 32'h0};

    assign mid     = {2'b00, p00_reg[63:32]} + {2'b00, p01_reg[31:0]} + {2'b00, p01_reg[31:0]};
    assign sq_lo   = {mid[31:0], p00_reg[31:0]};
    assign sq_hi   = prod_reg + {31'h0, p01_reg[63:32], 1'b0} + {62'h0, mid[33:32]};
    assign fold_k  = (sq_lo ^ sq_hi) ^ mix_key(cmd.fin ? cmd.round : lane_reg);
    assign mix_out = (fold_k << MIX_ROT) | (fold_k >> (64 - MIX_ROT));

    always_comb begin
        in_msg_next = in_msg_reg;
        rem_next    = rem_reg;
        slot_next   = slot_reg;
        full_next   = full_reg;
        case (cmd.op)
            OP_ACCEPT: begin
                if (first) begin
                    in_msg_next = 1'b1;
                    rem_next    = LENGTH_BITS'(message_length);
                    slot_next   = 2'd0;
                    full_next   = 1'b0;
                end
            end
            OP_PREP: begin
                rem_next  = (full_eff || rem_ge8) ? rem_reg - LENGTH_BITS'(8) : '0;
                slot_next = full_eff ? slot_reg + 2'd1 : slot_reg;
                full_next = full_eff && (slot_reg != 2'd3);
            end
            OP_FIN: begin
                in_msg_next = 1'b0;
                slot_next   = 2'd0;
                full_next   = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_msg_reg <= 1'b0;
            rem_reg    <= '0;
            slot_reg   <= 2'd0;
            full_reg   <= 1'b0;
        end else begin
            in_msg_reg <= in_msg_next;
            rem_reg    <= rem_next;
            slot_reg   <= slot_next;
            full_reg   <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        case (cmd.op)
            OP_ACCEPT: begin
                word_reg <= data_word;
                if (first) begin
                    acc_reg[0] <= seed ^ GOLD;
                    acc_reg[1] <= seed ^ MIXK1;
                    acc_reg[2] <= seed ^ MIXK2;
                    acc_reg[3] <= seed;
                end
            end
            OP_LEN1, OP_SQ1: begin
                p00_reg <= prod_reg;
            end
            OP_LEN2, OP_SQ2: begin
                p01_reg <= prod_reg;
            end
            OP_LEN3: begin
                acc_reg[3] <= acc_reg[3] ^ len_prod;
            end
            OP_PREP: begin
                z_reg    <= acc_reg[lane_eff] ^ word_mask;
                lane_reg <= lane_eff;
            end
            OP_SQ3: begin
                if (cmd.fin) begin
                    z_reg <= mix_out;
                end else begin
                    acc_reg[lane_reg] <= mix_out;
                end
            end
            OP_FIN: begin
                z_reg <= acc_reg[0] ^ acc_reg[1] ^ acc_reg[2] ^ acc_reg[3];
            end
            OP_LOAD: begin
                digest_reg <= z_reg;
            end
            default: begin
            end
        endcase
    end

    assign st.in_msg   = in_msg_reg;
    assign st.rem_zero = (rem_reg == '0);
    assign digest      = digest_reg;

endmodule

### src/sfh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfh_ctrl
// Sequencer for beat intake, length product, mix steps, finish rounds and
// the output register handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfh_ctrl
    import sfh_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [1:0] round_reg, round_next;
    logic       fin_mode_reg, fin_mode_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            round_reg     <= 2'd0;
            fin_mode_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            fin_mode_reg  <= fin_mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        round_next     = round_reg;
        fin_mode_next  = fin_mode_reg;
        out_valid_next = (out_valid_reg && !m_tready);
        cmd.op         = OP_NONE;
        cmd.fin        = fin_mode_reg;
        cmd.round      = round_reg;
        s_tready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_ACCEPT;
                    state_next = st.in_msg ? ST_PREP : ST_LEN0;
                end
            end
            ST_LEN0: begin
                cmd.op     = OP_LEN0;
                state_next = ST_LEN1;
            end
            ST_LEN1: begin
                cmd.op     = OP_LEN1;
                state_next = ST_LEN2;
            end
            ST_LEN2: begin
                cmd.op     = OP_LEN2;
                state_next = ST_LEN3;
            end
            ST_LEN3: begin
                cmd.op     = OP_LEN3;
                state_next = st.rem_zero ? ST_FIN : ST_PREP;
            end
            ST_PREP: begin
                cmd.op     = OP_PREP;
                state_next = ST_SQ0;
            end
            ST_SQ0: begin
                cmd.op     = OP_SQ0;
                state_next = ST_SQ1;
            end
            ST_SQ1: begin
                cmd.op     = OP_SQ1;
                state_next = ST_SQ2;
            end
            ST_SQ2: begin
                cmd.op     = OP_SQ2;
                state_next = ST_SQ3;
            end
            ST_SQ3: begin
                cmd.op = OP_SQ3;
                if (fin_mode_reg) begin
                    if (round_reg == 2'd3) begin
                        state_next = ST_OUT;
                    end else begin
                        round_next = round_reg + 2'd1;
                        state_next = ST_SQ0;
                    end
                end else begin
                    state_next = st.rem_zero ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN: begin
                cmd.op        = OP_FIN;
                fin_mode_next = 1'b1;
                round_next    = 2'd0;
                state_next    = ST_SQ0;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.op         = OP_LOAD;
                    out_valid_next = 1'b1;
                    fin_mode_next  = 1'b0;
                    round_next     = 2'd0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

    `SFH_ASSERT(a_no_intake_in_finish, !(fin_mode_reg && s_tready), "beat taken during finish")
    `SFH_ASSERT(a_round_only_in_finish, (round_reg == 2'd0) || fin_mode_reg, "stray round count")
    `SFH_ASSERT_NEXT(a_load_sets_valid, state_reg == ST_OUT && out_free, m_tvalid, "digest not shown")

endmodule

### src/square_fold_four_lane_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_fold_four_lane_hash
// Four-lane square-fold hash of a little-endian word stream into a 64-bit
// digest.
//
//   channel  dir  group            payload
//   input    in   s_tvalid/tready  s_tdata: seed, message_length, data_word
//   result   out  m_tvalid/tready  m_tdata: digest
//
// A beat inside a message passes through intake, lane select, and four steps
// of the shared 32x32 multiplier that builds each 64x64 square.
// The first beat of a message adds the length times golden product on that
// multiplier; the closing beat adds the four finish mixes and the output load.
// Reset (aresetn low, synchronous) closes any open message and drops the
// output register. A stalled m_tready holds the digest; intake continues
// until a second digest is ready to load.
// ----------------------------------------------------------------------------
module square_fold_four_lane_hash
    import sfh_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // seed[63:0], message_length[95:64], data_word[159:96]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata    // digest[63:0]
);

    cmd_t    cmd;
    status_t st;

    sfh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    sfh_datapath #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .st             (st),
        .seed           (s_tdata[63:0]),
        .message_length (s_tdata[95:64]),
        .data_word      (s_tdata[159:96]),
        .digest         (m_tdata)
    );

endmodule
